// ----- sv/mbn_pkg.sv -----
`timescale 1ns / 1ps

package mbn_pkg;

  // Block configuration
  localparam int CHANNELS          = 8;
  localparam int BANDPASS_SECTIONS = 4;
  localparam int SAMPLE_BITS       = 24;

  // Field and stream widths
  localparam int CH_W    = 3;
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  // Cascade: band-pass sections, then the 50 Hz and the 100 Hz notch
  localparam int NSEC     = BANDPASS_SECTIONS + 2;
  localparam int SEC_W    = (NSEC > 1) ? $clog2(NSEC) : 1;
  localparam int SEC_N50  = BANDPASS_SECTIONS;
  localparam int SEC_N100 = BANDPASS_SECTIONS + 1;

  // Delay storage: one row per channel and section, holding d1 and d2
  localparam int ROWS  = CHANNELS * NSEC;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Q32.16 signals and delays, Q3.30 coefficients
  localparam int D_W       = 48;
  localparam int FRAC      = 16;
  localparam int C_W       = 33;
  localparam int MAGC_W    = C_W - 1;
  localparam int COEF_FRAC = 30;
  localparam int HALF_W    = D_W / 2;
  localparam int PROD_W    = HALF_W + MAGC_W;
  localparam int LO_W      = PROD_W + 1;
  localparam int P_W       = D_W + 2;
  localparam int SUM_W     = D_W + 6;
  localparam int OUT_W     = D_W + 1 - FRAC;

  localparam logic signed [D_W-1:0] D_MAX = {1'b0, {(D_W-1){1'b1}}};
  localparam logic signed [D_W-1:0] D_MIN = {1'b1, {(D_W-1){1'b0}}};

  // Sequencer timing: five products per section, one issued on each even phase
  localparam int PH_W           = 4;
  localparam int SECTION_CYCLES = 10;

  // Product codes, in issue order within a section
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_B0 = 3'd0;
  localparam logic [OP_W-1:0] OP_B1 = 3'd1;
  localparam logic [OP_W-1:0] OP_B2 = 3'd2;
  localparam logic [OP_W-1:0] OP_A1 = 3'd3;
  localparam logic [OP_W-1:0] OP_A2 = 3'd4;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [OP_W-1:0]  op;
  } mul_tag_t;

  typedef struct packed {
    logic                  en;
    logic [ROW_W-1:0]      addr;
    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
  } mem_wr_t;

  // Rows: b0, b1, b2, a1, a2
  localparam logic signed [C_W-1:0] BP_K [4][5] = '{
    '{ 33'sd18726666,   33'sd37453332,   33'sd18726666,
       33'sd754703813,  -33'sd168072044 },
    '{ 33'sd1073741824, 33'sd2147483648, 33'sd1073741824,
       33'sd975874293,  -33'sd579274819 },
    '{ 33'sd1073741824, -33'sd2147483648, 33'sd1073741824,
       33'sd2109330301, -33'sd1035989014 },
    '{ 33'sd1073741824, -33'sd2147483648, 33'sd1073741824,
       33'sd2132112727, -33'sd1058754392 }
  };
  localparam logic signed [C_W-1:0] N50_K [5] = '{
    33'sd1057118651, -33'sd1241103275, 33'sd1057118651,
    33'sd1241103275, -33'sd1040495479
  };
  localparam logic signed [C_W-1:0] N100_K [5] = '{
    33'sd1040994485, 33'sd647104943, 33'sd1040994485,
    -33'sd647104943, -33'sd1008247147
  };

  function automatic logic signed [C_W-1:0] coef(input logic [SEC_W-1:0] sec,
                                                 input logic [OP_W-1:0] op);
    int unsigned i;
    logic signed [C_W-1:0] r;
    case (op)
      OP_B0:   i = 0;
      OP_B1:   i = 1;
      OP_B2:   i = 2;
      OP_A1:   i = 3;
      OP_A2:   i = 4;
      default: i = 0;
    endcase
    if (int'(sec) < BANDPASS_SECTIONS) begin
      r = BP_K[int'(sec) % 4][i];
    end else if (int'(sec) == SEC_N50) begin
      r = N50_K[i];
    end else begin
      r = N100_K[i];
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] row_addr(input logic [CH_W-1:0] ch,
                                                input logic [SEC_W-1:0] sec);
    int unsigned r;
    r = int'(ch) * NSEC + int'(sec);
    return ROW_W'(r);
  endfunction

  function automatic logic signed [D_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [D_W-1:0]   r;
    hi = SUM_W'(D_MAX);
    lo = SUM_W'(D_MIN);
    if (v > hi) begin
      r = D_MAX;
    end else if (v < lo) begin
      r = D_MIN;
    end else begin
      r = v[D_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/mbn_mul.sv -----
`timescale 1ns / 1ps

// Rounded Q32.16 x Q3.30 product on one 24x32 multiplier, used twice per product.
// Issues may not come back to back, as each product uses the multiplier twice. The
// result passes operand, low-half, high-half and result registers, with its tag.
module mbn_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  logic signed [mbn_pkg::D_W-1:0]      x,
  input  logic signed [mbn_pkg::C_W-1:0]      c,
  input  mbn_pkg::mul_tag_t                   tag,
  output logic                                res_valid,
  output logic signed [mbn_pkg::P_W-1:0]      res,
  output mbn_pkg::mul_tag_t                   res_tag
);

  localparam logic [mbn_pkg::LO_W-1:0] LO_RND =
    mbn_pkg::LO_W'(1) << (mbn_pkg::COEF_FRAC - 1);
  localparam int SHIFT = mbn_pkg::COEF_FRAC - mbn_pkg::HALF_W;

  logic                              v1, v2, v3;
  logic [mbn_pkg::D_W-1:0]           ax;
  logic [mbn_pkg::MAGC_W-1:0]        ac;
  logic                              neg1, neg2, neg3;
  mbn_pkg::mul_tag_t                 tag1, tag2, tag3;
  logic [mbn_pkg::LO_W-1:0]          lo;
  logic [mbn_pkg::PROD_W-1:0]        hi;

  logic [mbn_pkg::HALF_W-1:0]        mul_a;
  logic [mbn_pkg::PROD_W-1:0]        prod;
  logic [mbn_pkg::LO_W-1:0]          sum;
  logic [mbn_pkg::P_W-2:0]           mag;

  // Low half in the cycle after issue, high half in the one after that
  always_comb begin
    mul_a = v2 ? ax[mbn_pkg::D_W-1:mbn_pkg::HALF_W] : ax[mbn_pkg::HALF_W-1:0];
    prod  = mul_a * ac;
    sum   = mbn_pkg::LO_W'(hi) + (lo >> mbn_pkg::HALF_W);
    mag   = sum[SHIFT +: mbn_pkg::P_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= issue;
      v2        <= v1;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ax   <= x[mbn_pkg::D_W-1] ? unsigned'(-x) : unsigned'(x);
      ac   <= c[mbn_pkg::C_W-1] ? mbn_pkg::MAGC_W'(unsigned'(-c))
                                : mbn_pkg::MAGC_W'(unsigned'(c));
      neg1 <= x[mbn_pkg::D_W-1] ^ c[mbn_pkg::C_W-1];
      tag1 <= tag;
    end
    if (v1) begin
      lo   <= mbn_pkg::LO_W'(prod) + LO_RND;
      neg2 <= neg1;
      tag2 <= tag1;
    end
    if (v2) begin
      hi   <= prod;
      neg3 <= neg2;
      tag3 <= tag2;
    end
    if (v3) begin
      res     <= neg3 ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      res_tag <= tag3;
    end
  end

endmodule

// ----- sv/mbn_state_mem.sv -----
`timescale 1ns / 1ps

// Per-channel, per-section delay pairs. Rows never written since reset read as zero.
module mbn_state_mem (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rd_en,
  input  logic [mbn_pkg::ROW_W-1:0]        rd_addr,
  output logic signed [mbn_pkg::D_W-1:0]   rd_d1,
  output logic signed [mbn_pkg::D_W-1:0]   rd_d2,
  input  mbn_pkg::mem_wr_t                 wr
);

  logic [2*mbn_pkg::D_W-1:0] mem [mbn_pkg::ROWS];
  logic [mbn_pkg::ROWS-1:0]  vld;
  logic [2*mbn_pkg::D_W-1:0] rd_q;
  logic                      rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.d2, wr.d1};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_d1 = rd_vld ? signed'(rd_q[mbn_pkg::D_W-1:0]) : '0;
  assign rd_d2 = rd_vld ? signed'(rd_q[2*mbn_pkg::D_W-1:mbn_pkg::D_W]) : '0;

endmodule

// ----- sv/multichannel_bandpass_notch_iir.sv -----
`timescale 1ns / 1ps

// Multichannel EEG filter: four band-pass biquads, a 50 Hz notch and a 100 Hz
// notch in cascade, transposed direct form II, with separate delay state per channel.
//
// Input stream (s_axis): one transaction is one sample of one channel. tdata holds
// the signed sample, tuser the channel, tlast the end-of-block mark, which is only
// carried to the output. Output stream (m_axis) has the same layout: filtered
// sample (rounded, saturated), channel and tlast.
//
// Throughput: one sample at a time. An accepted sample shows up on m_axis once
// the cascade is done, and s_axis_tready rises again in that cycle. The pace comes
// from one shared 24x32 multiplier: each of the 30 products (five per section, six
// sections) takes two passes through it. A channel number outside the configured
// range passes the sample unchanged.
//
// Reset clears the sequencer and marks every delay row as zero; no sweep is
// needed. When m_axis_tready is low, the finished sample waits in the output
// register; the next sample is still accepted and filtered, and holds at the end
// until the output register frees up.
module multichannel_bandpass_notch_iir (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mbn_pkg::TDATA_W-1:0]      s_axis_tdata,   // [23:0] sample_in
  input  logic [mbn_pkg::CH_W-1:0]         s_axis_tuser,   // [2:0] channel
  input  logic                             s_axis_tlast,   // last_of_block
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mbn_pkg::TDATA_W-1:0]      m_axis_tdata,   // [23:0] sample_out
  output logic [mbn_pkg::CH_W-1:0]         m_axis_tuser,   // [2:0] channel_out
  output logic                             m_axis_tlast    // last_out
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam int SB = mbn_pkg::SAMPLE_BITS;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [mbn_pkg::D_W:0] HALF_LSB =
    (mbn_pkg::D_W+1)'(1) <<< (mbn_pkg::FRAC - 1);

  // Control
  logic [1:0]                      state;
  logic                            issuing;
  logic [mbn_pkg::SEC_W-1:0]       sec_i;
  logic [mbn_pkg::PH_W-1:0]        ph;

  // Payload
  logic [mbn_pkg::CH_W-1:0]        ch;
  logic                            last_r;
  logic signed [mbn_pkg::D_W-1:0]  y;
  logic signed [mbn_pkg::SUM_W-1:0] acc1;
  logic signed [mbn_pkg::P_W-1:0]  acc2;
  logic signed [mbn_pkg::D_W-1:0]  d1n;
  logic [SB-1:0]                   out_sample;

  // Datapath wires
  logic                            accept;
  logic                            in_range;
  logic signed [SB-1:0]            sample;
  logic signed [mbn_pkg::D_W-1:0]  sample_ext;
  logic signed [mbn_pkg::D_W-1:0]  x0;
  logic                            mul_issue;
  mbn_pkg::mul_tag_t               mul_tag;
  logic                            res_valid;
  logic signed [mbn_pkg::P_W-1:0]  res;
  mbn_pkg::mul_tag_t               res_tag;
  logic                            rd_en;
  logic signed [mbn_pkg::D_W-1:0]  rd_d1;
  logic signed [mbn_pkg::D_W-1:0]  rd_d2;
  mbn_pkg::mem_wr_t                wr;
  logic                            last_sec_done;
  logic                            out_free;
  logic signed [mbn_pkg::D_W:0]    y_rnd;
  logic signed [mbn_pkg::OUT_W-1:0] y_int;
  logic signed [SB-1:0]            y_sat;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = int'(s_axis_tuser) < mbn_pkg::CHANNELS;

  // Input sample into Q32.16
  assign sample     = signed'(s_axis_tdata[SB-1:0]);
  assign sample_ext = mbn_pkg::D_W'(sample);
  assign x0         = sample_ext <<< mbn_pkg::FRAC;

  // Issue one product on every even phase; the operand is always y, which holds
  // the section input until its y result lands, then the section output.
  assign mul_issue   = (state == ST_RUN) && issuing && !ph[0];
  assign mul_tag.sec = sec_i;
  assign mul_tag.op  = ph[mbn_pkg::PH_W-1:1];

  // Fetch the section's delay pair at its first phase; it holds for the section.
  assign rd_en = (state == ST_RUN) && issuing && (ph == '0);

  mbn_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .issue     (mul_issue),
    .x         (y),
    .c         (mbn_pkg::coef(sec_i, mul_tag.op)),
    .tag       (mul_tag),
    .res_valid (res_valid),
    .res       (res),
    .res_tag   (res_tag)
  );

  // Write back the new delay pair when the a2 product of a section completes
  always_comb begin
    wr.en   = res_valid && (res_tag.op == mbn_pkg::OP_A2);
    wr.addr = mbn_pkg::row_addr(ch, res_tag.sec);
    wr.d1   = d1n;
    wr.d2   = mbn_pkg::sat48(mbn_pkg::SUM_W'(acc2) + mbn_pkg::SUM_W'(res));
  end

  mbn_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (mbn_pkg::row_addr(ch, sec_i)),
    .rd_d1   (rd_d1),
    .rd_d2   (rd_d2),
    .wr      (wr)
  );

  assign last_sec_done = wr.en && (int'(res_tag.sec) == mbn_pkg::NSEC - 1);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Round half up to an integer, then clamp to the sample range
  always_comb begin
    y_rnd = (mbn_pkg::D_W+1)'(y) + HALF_LSB;
    y_int = y_rnd[mbn_pkg::D_W:mbn_pkg::FRAC];
    if (y_int > mbn_pkg::OUT_W'(S_MAX)) begin
      y_sat = S_MAX;
    end else if (y_int < mbn_pkg::OUT_W'(S_MIN)) begin
      y_sat = S_MIN;
    end else begin
      y_sat = y_int[SB-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      issuing       <= 1'b0;
      sec_i         <= '0;
      ph            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Load the output register from the drain state, drop it once taken
      if (state == ST_DRAIN && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sec_i <= '0;
            ph    <= '0;
            if (in_range) begin
              issuing <= 1'b1;
              state   <= ST_RUN;
            end else begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_RUN: begin
          if (issuing) begin
            if (ph == mbn_pkg::PH_W'(mbn_pkg::SECTION_CYCLES - 1)) begin
              ph <= '0;
              if (int'(sec_i) == mbn_pkg::NSEC - 1) begin
                issuing <= 1'b0;
              end else begin
                sec_i <= sec_i + 1'b1;
              end
            end else begin
              ph <= ph + 1'b1;
            end
          end
          if (last_sec_done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // Hold the finished sample until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Section arithmetic, driven by the tag of each finished product
  always_ff @(posedge clk) begin
    if (accept) begin
      ch     <= s_axis_tuser;
      last_r <= s_axis_tlast;
      y      <= x0;
    end
    if (res_valid) begin
      case (res_tag.op)
        mbn_pkg::OP_B0: y    <= mbn_pkg::sat48(mbn_pkg::SUM_W'(res) +
                                               mbn_pkg::SUM_W'(rd_d1));
        mbn_pkg::OP_B1: acc1 <= mbn_pkg::SUM_W'(res) + mbn_pkg::SUM_W'(rd_d2);
        mbn_pkg::OP_B2: acc2 <= res;
        mbn_pkg::OP_A1: d1n  <= mbn_pkg::sat48(acc1 + mbn_pkg::SUM_W'(res));
        default: begin
        end
      endcase
    end
    if (state == ST_DRAIN && out_free) begin
      out_sample   <= unsigned'(y_sat);
      m_axis_tuser <= ch;
      m_axis_tlast <= last_r;
    end
  end

  assign m_axis_tdata = mbn_pkg::TDATA_W'(out_sample);

endmodule

// ----- tb/sv/cascade_checker.sv -----
`timescale 1ns / 1ps

module cascade_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [mbn_pkg::TDATA_W-1:0]      s_tdata,   // [23:0] sample_in
  input  logic [mbn_pkg::CH_W-1:0]         s_tuser,   // [2:0] channel
  input  logic                             s_tlast,   // last_of_block
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [mbn_pkg::TDATA_W-1:0]      m_tdata,   // [23:0] sample_out
  input  logic [mbn_pkg::CH_W-1:0]         m_tuser,   // [2:0] channel_out
  input  logic                             m_tlast,   // last_out
  output int                               mismatches,
  output int                               outstanding,
  output int                               compared
);

  localparam longint D_TOP   = 64'sd140737488355327;
  localparam longint D_BOT   = -D_TOP - 1;
  localparam longint SMP_TOP = (64'sd1 <<< (mbn_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_BOT = -SMP_TOP - 1;

  typedef struct packed {
    logic [mbn_pkg::CH_W-1:0]               channel;
    logic signed [mbn_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   last;
  } filtered_t;

  // Q3.30 rows b0, b1, b2, a1, a2: four band-pass rows, then 50 Hz and 100 Hz notch
  longint coef_tab [6][5] = '{
    '{18726666, 37453332, 18726666, 754703813, -168072044},
    '{1073741824, 64'sd2147483648, 1073741824, 975874293, -579274819},
    '{1073741824, -64'sd2147483648, 1073741824, 2109330301, -1035989014},
    '{1073741824, -64'sd2147483648, 1073741824, 2132112727, -1058754392},
    '{1057118651, -1241103275, 1057118651, 1241103275, -1040495479},
    '{1040994485, 647104943, 1040994485, -647104943, -1008247147}
  };

  // Per channel and section: d1, d2 in Q32.16
  longint    delay_line [mbn_pkg::CHANNELS][mbn_pkg::NSEC][2];
  filtered_t filtered_q [$];
  int        mismatch_n;
  int        compared_n;

  // round(x*c / 2^30), ties away from zero
  function automatic longint mul_q30(input longint x, input longint c);
    logic [127:0] mag;
    logic [63:0]  ax;
    logic [63:0]  ac;
    ax  = (x < 0) ? -x : x;
    ac  = (c < 0) ? -c : c;
    mag = ax * ac;
    mag = (mag + (128'd1 << 29)) >> 30;
    return ((x < 0) != (c < 0)) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint clamp_q16(input longint v);
    if (v > D_TOP) return D_TOP;
    if (v < D_BOT) return D_BOT;
    return v;
  endfunction

  function automatic longint filter_sample(input int ch, input longint smp);
    longint y;
    longint yo;
    longint d1n;
    longint d2n;
    longint r;
    int     sec;
    int     row;
    if (ch >= mbn_pkg::CHANNELS) return smp;
    y = smp * 65536;
    for (sec = 0; sec < mbn_pkg::NSEC; sec++) begin
      if (sec < mbn_pkg::BANDPASS_SECTIONS) begin
        row = sec % 4;
      end else if (sec == mbn_pkg::BANDPASS_SECTIONS) begin
        row = 4;
      end else begin
        row = 5;
      end
      yo  = clamp_q16(mul_q30(y, coef_tab[row][0]) + delay_line[ch][sec][0]);
      d1n = clamp_q16(mul_q30(y, coef_tab[row][1]) + mul_q30(yo, coef_tab[row][3])
                      + delay_line[ch][sec][1]);
      d2n = clamp_q16(mul_q30(y, coef_tab[row][2]) + mul_q30(yo, coef_tab[row][4]));
      delay_line[ch][sec][0] = d1n;
      delay_line[ch][sec][1] = d2n;
      y = yo;
    end
    // round half up to whole samples, then clip to the sample range
    r = (y + 32768) >>> 16;
    if (r > SMP_TOP) r = SMP_TOP;
    if (r < SMP_BOT) r = SMP_BOT;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    filtered_t want;
    filtered_t got;
    longint    smp;
    if (rst) begin
      filtered_q.delete();
      foreach (delay_line[c, s, k]) delay_line[c][s][k] = 0;
      mismatch_n = 0;
      compared_n = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.channel = m_tuser;
        got.sample  = $signed(m_tdata[mbn_pkg::SAMPLE_BITS-1:0]);
        got.last    = m_tlast;
        if (filtered_q.size() == 0) begin
          mismatch_n++;
          $display("%0t: unexpected output ch %0d sample %0d last %0b",
                   $time, got.channel, got.sample, got.last);
        end else begin
          want = filtered_q.pop_front();
          compared_n++;
          if (got.channel != want.channel) begin
            mismatch_n++;
            $display("%0t: channel expected %0d actual %0d",
                     $time, want.channel, got.channel);
          end
          if (got.sample != want.sample) begin
            mismatch_n++;
            $display("%0t: sample (ch %0d) expected %0d actual %0d",
                     $time, want.channel, want.sample, got.sample);
          end
          if (got.last != want.last) begin
            mismatch_n++;
            $display("%0t: tlast (ch %0d) expected %0b actual %0b",
                     $time, want.channel, want.last, got.last);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        smp          = longint'($signed(s_tdata[mbn_pkg::SAMPLE_BITS-1:0]));
        want.channel = s_tuser;
        want.last    = s_tlast;
        want.sample  = mbn_pkg::SAMPLE_BITS'(filter_sample(int'(s_tuser), smp));
        filtered_q.push_back(want);
      end
    end
    mismatches  <= mismatch_n;
    compared    <= compared_n;
    outstanding <= filtered_q.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int SMP_MAX        = (1 << (mbn_pkg::SAMPLE_BITS - 1)) - 1;
  localparam int SMP_MIN        = -SMP_MAX - 1;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 80;

  typedef enum logic [2:0] {
    PH_DIRECTED,
    PH_FREE,
    PH_TX_IDLE,
    PH_RX_STALL,
    PH_BOTH_STALL,
    PH_HOLD
  } phase_e;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mbn_pkg::TDATA_W-1:0]   s_axis_tdata = '0;   // [23:0] sample_in
  logic [mbn_pkg::CH_W-1:0]      s_axis_tuser = '0;   // [2:0] channel
  logic                          s_axis_tlast = 1'b0; // last_of_block
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mbn_pkg::TDATA_W-1:0]   m_axis_tdata;        // [23:0] sample_out
  logic [mbn_pkg::CH_W-1:0]      m_axis_tuser;        // [2:0] channel_out
  logic                          m_axis_tlast;        // last_out

  phase_e phase       = PH_DIRECTED;
  int     hold_left   = HOLD_CYCLES;
  int     quiet_cycles = 0;
  int     tx_idle_pct = 0;
  int     samples_sent = 0;
  int     square_step [mbn_pkg::CHANNELS];
  int     mismatches;
  int     outstanding;
  int     compared;

  multichannel_bandpass_notch_iir dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  cascade_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .s_tlast     (s_axis_tlast),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .m_tuser     (m_axis_tuser),
    .m_tlast     (m_axis_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: one long hold-off in the hold phase, random stalls in the
  // stall phases, always ready otherwise.
  always @(posedge clk) begin
    if (phase == PH_HOLD && hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (phase == PH_RX_STALL) begin
      m_axis_tready <= ($urandom_range(99) >= 74);
    end else if (phase == PH_BOTH_STALL) begin
      m_axis_tready <= ($urandom_range(99) >= 19);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Abort when neither side completes a transaction for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample, with random gaps ahead of it when the phase asks for
  // them, and hold it until the block takes it.
  task automatic send_sample(input int ch, input int smp, input bit lst);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mbn_pkg::TDATA_W'(smp[mbn_pkg::SAMPLE_BITS-1:0]);
    s_axis_tuser  <= ch[mbn_pkg::CH_W-1:0];
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid and wait for every filtered sample still in flight.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int pick_sample();
    logic [mbn_pkg::SAMPLE_BITS-1:0] raw;
    int unsigned                     sel;
    sel = $urandom_range(9);
    raw = mbn_pkg::SAMPLE_BITS'($urandom);
    if (sel < 4) return int'($signed(raw));
    if (sel < 6) return int'($urandom_range(4000)) - 2000;
    if (sel < 8) return raw[0] ? SMP_MAX : SMP_MIN;
    return raw[0] ? SMP_MAX - int'(raw[8:1]) : SMP_MIN + int'(raw[8:1]);
  endfunction

  // Full-scale square wave, period eight samples: sits in the pass band and
  // drives the cascade into output clipping.
  function automatic int square_sample(input int ch);
    square_step[ch]++;
    return (square_step[ch] & 4) ? SMP_MAX : SMP_MIN;
  endfunction

  // Mostly whole frames (one sample per channel, tlast on the last one),
  // with some stray single samples carrying a random tlast.
  task automatic random_traffic(input int n);
    int  done;
    int  ch;
    bit  sq;
    done = 0;
    while (done < n) begin
      if ($urandom_range(99) < 80) begin
        sq = ($urandom_range(3) == 0);
        for (ch = 0; ch < mbn_pkg::CHANNELS; ch++) begin
          send_sample(ch, sq ? square_sample(ch) : pick_sample(),
                      ch == mbn_pkg::CHANNELS - 1);
          done++;
        end
      end else begin
        send_sample(int'($urandom_range(mbn_pkg::CHANNELS - 1)), pick_sample(),
                    1'($urandom_range(1)));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    int ch;
    foreach (square_step[i]) square_step[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, sign edges, bit patterns, impulse and ringing,
    // every channel and both tlast values.
    send_sample(0, 0, 1'b0);
    send_sample(0, SMP_MAX, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(0, SMP_MIN, 1'b1);
    send_sample(0, SMP_MAX, 1'b0);
    send_sample(0, -1, 1'b0);
    send_sample(0, 1, 1'b1);
    send_sample(3, 24'h555555, 1'b0);
    send_sample(3, -24'sh555556, 1'b1);
    for (ch = 0; ch < mbn_pkg::CHANNELS; ch++) begin
      send_sample(ch, (ch % 2) ? SMP_MIN : SMP_MAX, ch == mbn_pkg::CHANNELS - 1);
    end
    send_sample(7, SMP_MIN, 1'b1);
    send_sample(7, SMP_MAX, 1'b0);
    send_sample(7, SMP_MIN, 1'b1);
    drain_results();

    phase <= PH_FREE;
    tx_idle_pct = 0;
    random_traffic(200);
    drain_results();

    phase <= PH_TX_IDLE;
    tx_idle_pct = 74;
    random_traffic(150);
    drain_results();

    phase <= PH_RX_STALL;
    tx_idle_pct = 0;
    random_traffic(150);
    drain_results();

    phase <= PH_BOTH_STALL;
    tx_idle_pct = 19;
    random_traffic(150);
    drain_results();

    // Receiver holds off while samples keep coming: output register and the
    // pipeline fill up and the input stalls.
    phase <= PH_HOLD;
    tx_idle_pct = 0;
    random_traffic(40);
    drain_results();

    phase <= PH_FREE;
    random_traffic(80);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d samples on %0d channels, %0d filtered results compared",
             samples_sent, mbn_pkg::CHANNELS, compared);
    $display("summary: extremes, square-wave clipping, sender gaps, receiver stalls, long hold-off");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
